// ===== design/set_assoc_lru_cache_tracker_core_macros.svh =====
// Assertion macros for the set-associative LRU cache tracker.
// Taken in by the checker module; depends on nothing else.
`ifndef SET_ASSOC_LRU_CACHE_TRACKER_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/sltr_pkg.sv =====
// Shared types and constants of the set-associative LRU cache tracker.
// Depends on nothing; used by the way scan, the core, the checker and the testbench.
package sltr_pkg;

	localparam int ADDR_W      = 64;
	localparam int TAG_W       = 64;
	localparam int TOTAL_W     = 32;
	localparam int S_TDATA_W   = 64;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 104;
	localparam int M_PAD_W     = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int SET_BITS_W  = 4;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_USED_W = 4;

	// Access kinds carried in s_tuser.
	localparam logic [S_TUSER_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [S_TUSER_W-1:0] OP_STORE  = 2'd1;
	localparam logic [S_TUSER_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [S_TUSER_W-1:0] OP_INSTR  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_USED  = 2'd2;

	// Bit positions of the result flags in m_tdata.
	localparam int MB_HIT   = 0;
	localparam int MB_MISS  = 1;
	localparam int MB_EVICT = 2;

	// Running state of the way scan.
	typedef struct packed {
		logic hit;
		logic free;
	} scan_flags_t;

endpackage

// ===== design/sltr_row_mem.sv =====
// Set row memory: one row holds valid, tag and age of every way of a set.
// One write port and one read port with registered read data; no package use.
module sltr_row_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 776
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sltr_way_scan.sv =====
// Shared way compare unit: folds one way per cycle into the hit and victim search.
// Depends on sltr_pkg for the scan flag struct.
module sltr_way_scan #(
	parameter int AGE_WIDTH = 32,
	parameter int WAY_W     = 3
) (
	input  logic [WAY_W-1:0]           way_idx,
	input  logic                       way_valid,
	input  logic [sltr_pkg::TAG_W-1:0] way_tag,
	input  logic [AGE_WIDTH-1:0]       way_age,
	input  logic [sltr_pkg::TAG_W-1:0] look_tag,
	input  sltr_pkg::scan_flags_t      cur_flags,
	input  logic [WAY_W-1:0]           cur_hit_way,
	input  logic [WAY_W-1:0]           cur_free_way,
	input  logic [WAY_W-1:0]           cur_best_way,
	input  logic [AGE_WIDTH-1:0]       cur_best_age,
	output sltr_pkg::scan_flags_t      nxt_flags,
	output logic [WAY_W-1:0]           nxt_hit_way,
	output logic [WAY_W-1:0]           nxt_free_way,
	output logic [WAY_W-1:0]           nxt_best_way,
	output logic [AGE_WIDTH-1:0]       nxt_best_age
);

	logic match;

	assign match = way_valid && (way_tag == look_tag);

	always_comb begin
		nxt_flags    = cur_flags;
		nxt_hit_way  = cur_hit_way;
		nxt_free_way = cur_free_way;
		nxt_best_way = cur_best_way;
		nxt_best_age = cur_best_age;
		// The first matching way wins.
		if (!cur_flags.hit && match) begin
			nxt_flags.hit = 1'b1;
			nxt_hit_way   = way_idx;
		end
		// Once a free way is found the oldest-way search no longer matters.
		if (!cur_flags.free) begin
			if (!way_valid) begin
				nxt_flags.free = 1'b1;
				nxt_free_way   = way_idx;
			end else if (way_age > cur_best_age) begin
				nxt_best_age = way_age;
				nxt_best_way = way_idx;
			end
		end
	end

endmodule

// ===== design/set_assoc_lru_cache_tracker_core.sv =====
// Set-associative cache tracker with LRU replacement, tags only. The address
// of each load, store or modify access is split into block offset, set index
// and tag under the configured geometry, and the used ways of the set are
// searched; each access yields one result transfer with hit, miss and
// eviction flags plus saturating running totals. A modify gives two results
// (tlast low on the first), an instruction access is taken and dropped.
// The effective way count is 1 to MAX_WAYS. The way scan reads the set
// row once and passes one way per cycle through a single compare unit,
// then the row is written back; a modify runs the lookup, scan and
// write-back twice. An instruction access leaves the block idle.
// s_tready stays low while an access is in progress, and the write-back
// stalls while an earlier result waits on m_tready. After reset a clearing
// pass zeroes every row of the row memory; inputs are not accepted during
// it, configuration writes are.
// Depends on sltr_pkg, sltr_row_mem and sltr_way_scan.
module set_assoc_lru_cache_tracker_core #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int AGE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,

	// Input access stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sltr_pkg::S_TDATA_W-1:0] s_tdata,  // [63:0] address
	input  logic [sltr_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] operation

	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] hit, [1] miss, [2] eviction, [34:3] hit_total,
	// [66:35] miss_total, [98:67] eviction_total, [103:99] zero
	output logic [sltr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast,

	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sltr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sltr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	// Largest k with 2^k not above MAX_SETS.
	localparam int MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
	localparam int ROW_W = MAX_WAYS * (1 + sltr_pkg::TAG_W + AGE_WIDTH);
	localparam int TAG_W = sltr_pkg::TAG_W;
	localparam int TOT_W = sltr_pkg::TOTAL_W;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOOKUP = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;

	logic [2:0] state_q;
	logic [SET_W-1:0] clr_q;

	// Configuration registers.
	logic [sltr_pkg::SET_BITS_W-1:0]   set_bits_q;
	logic [sltr_pkg::BLOCK_BITS_W-1:0] block_bits_q;
	logic [sltr_pkg::WAYS_USED_W-1:0]  ways_used_q;

	// Access in progress.
	logic [sltr_pkg::ADDR_W-1:0] addr_q;
	logic                        second_q;
	logic [SET_W-1:0]            set_q;
	logic [TAG_W-1:0]            tag_q;
	logic [WAY_W-1:0]            way_q;

	// Scan accumulators.
	sltr_pkg::scan_flags_t flags_q;
	logic [WAY_W-1:0]      hit_way_q;
	logic [WAY_W-1:0]      free_way_q;
	logic [WAY_W-1:0]      best_way_q;
	logic [AGE_WIDTH-1:0]  best_age_q;

	sltr_pkg::scan_flags_t nxt_flags;
	logic [WAY_W-1:0]      nxt_hit_way;
	logic [WAY_W-1:0]      nxt_free_way;
	logic [WAY_W-1:0]      nxt_best_way;
	logic [AGE_WIDTH-1:0]  nxt_best_age;

	// Totals and output register.
	logic [TOT_W-1:0] hit_tot_q;
	logic [TOT_W-1:0] miss_tot_q;
	logic [TOT_W-1:0] evict_tot_q;
	logic             out_valid_q;
	logic             out_hit_q;
	logic             out_miss_q;
	logic             out_evict_q;
	logic             out_last_q;

	// Row memory views.
	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] wr_row;
	logic [MAX_WAYS-1:0]                rd_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]     rd_tag;
	logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] rd_age;
	logic [MAX_WAYS-1:0]                wr_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]     wr_tag;
	logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] wr_age;

	logic             mem_we;
	logic [SET_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;
	logic             mem_re;

	logic                        in_fire;
	logic                        write_fire;
	logic [WAY_W-1:0]            last_way;
	logic [WAY_W-1:0]            pick;
	logic [3:0]                  sb_eff;
	logic [SET_W-1:0]            set_mask;
	logic [sltr_pkg::ADDR_W-1:0] set_shifted;
	logic [SET_W-1:0]            set_calc;
	logic [6:0]                  tag_shift;
	logic [TAG_W-1:0]            tag_calc;

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign write_fire = (state_q == ST_WRITE) && (!out_valid_q || m_tready);

	// Effective way count minus one: zero ways act as one, too many as MAX_WAYS.
	always_comb begin
		if (ways_used_q == '0) begin
			last_way = '0;
		end else if (32'(ways_used_q) > 32'(MAX_WAYS)) begin
			last_way = WAY_W'(MAX_WAYS - 1);
		end else begin
			last_way = WAY_W'(ways_used_q - 4'd1);
		end
	end

	// Address split. The set field is clamped to what the memory can index,
	// and the clamped width also decides where the tag starts.
	assign sb_eff = (32'(set_bits_q) > 32'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_q;
	assign set_mask    = ~({SET_W{1'b1}} << sb_eff);
	assign set_shifted = addr_q >> block_bits_q;
	assign set_calc    = set_shifted[SET_W-1:0] & set_mask;
	assign tag_shift   = {1'b0, block_bits_q} + {3'b000, sb_eff};
	assign tag_calc    = tag_shift[6] ? '0 : (addr_q >> tag_shift[5:0]);

	assign {rd_age, rd_tag, rd_valid} = rd_row;
	assign wr_row = {wr_age, wr_tag, wr_valid};

	// Chosen way: the hit, else the first free way, else the oldest one.
	assign pick = flags_q.hit ? hit_way_q : (flags_q.free ? free_way_q : best_way_q);

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			wr_valid[w] = rd_valid[w];
			wr_tag[w]   = rd_tag[w];
			wr_age[w]   = rd_age[w];
			if (WAY_W'(w) == pick) begin
				wr_age[w] = '0;
				if (!flags_q.hit) begin
					wr_valid[w] = 1'b1;
					wr_tag[w]   = tag_q;
				end
			end else if (WAY_W'(w) <= last_way) begin
				wr_age[w] = (rd_age[w] == '1) ? rd_age[w] : rd_age[w] + AGE_WIDTH'(1);
			end
		end
	end

	// Memory port selection: the clearing pass owns the write port after reset.
	assign mem_we    = (state_q == ST_CLEAR) || write_fire;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;
	assign mem_re    = (state_q == ST_LOOKUP);

	sltr_row_mem #(
		.DEPTH  (MAX_SETS),
		.ADDR_W (SET_W),
		.DATA_W (ROW_W)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (set_calc),
		.rdata (rd_row)
	);

	sltr_way_scan #(
		.AGE_WIDTH (AGE_WIDTH),
		.WAY_W     (WAY_W)
	) u_way_scan (
		.way_idx      (way_q),
		.way_valid    (rd_valid[way_q]),
		.way_tag      (rd_tag[way_q]),
		.way_age      (rd_age[way_q]),
		.look_tag     (tag_q),
		.cur_flags    (flags_q),
		.cur_hit_way  (hit_way_q),
		.cur_free_way (free_way_q),
		.cur_best_way (best_way_q),
		.cur_best_age (best_age_q),
		.nxt_flags    (nxt_flags),
		.nxt_hit_way  (nxt_hit_way),
		.nxt_free_way (nxt_free_way),
		.nxt_best_way (nxt_best_way),
		.nxt_best_age (nxt_best_age)
	);

	// Configuration registers take a write in any state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd4;
			block_bits_q <= 6'd4;
			ways_used_q  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sltr_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				sltr_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				sltr_pkg::REG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			second_q    <= 1'b0;
			way_q       <= '0;
			flags_q     <= '0;
			hit_tot_q   <= '0;
			miss_tot_q  <= '0;
			evict_tot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (32'(clr_q) == 32'(MAX_SETS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + SET_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_fire && (s_tuser != sltr_pkg::OP_INSTR)) begin
						second_q <= (s_tuser == sltr_pkg::OP_MODIFY);
						state_q  <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					way_q   <= '0;
					flags_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					flags_q <= nxt_flags;
					if (way_q == last_way) begin
						state_q <= ST_WRITE;
					end else begin
						way_q <= way_q + WAY_W'(1);
					end
				end
				ST_WRITE: begin
					if (write_fire) begin
						out_valid_q <= 1'b1;
						if (flags_q.hit) begin
							if (hit_tot_q != '1) hit_tot_q <= hit_tot_q + TOT_W'(1);
						end else begin
							if (miss_tot_q != '1) miss_tot_q <= miss_tot_q + TOT_W'(1);
							if (!flags_q.free && (evict_tot_q != '1)) begin
								evict_tot_q <= evict_tot_q + TOT_W'(1);
							end
						end
						// The second half of a modify rereads the row just written.
						if (second_q) begin
							second_q <= 1'b0;
							state_q  <= ST_LOOKUP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= s_tdata;
		end
		if (state_q == ST_LOOKUP) begin
			set_q      <= set_calc;
			tag_q      <= tag_calc;
			hit_way_q  <= '0;
			free_way_q <= '0;
			best_way_q <= '0;
			best_age_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			hit_way_q  <= nxt_hit_way;
			free_way_q <= nxt_free_way;
			best_way_q <= nxt_best_way;
			best_age_q <= nxt_best_age;
		end
		if (write_fire) begin
			out_hit_q   <= flags_q.hit;
			out_miss_q  <= !flags_q.hit;
			out_evict_q <= !flags_q.hit && !flags_q.free;
			out_last_q  <= !second_q;
		end
	end

	// Totals only move when a new result is loaded, so the running counters
	// always match the result on display.
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{sltr_pkg::M_PAD_W{1'b0}}, evict_tot_q, miss_tot_q, hit_tot_q,
		out_evict_q, out_miss_q, out_hit_q};

endmodule

// ===== design/sltr_checker.sv =====
// Port-level checker for the set-associative LRU cache tracker, bound to the top.
// Depends on sltr_pkg and the assertion macro header.
`include "set_assoc_lru_cache_tracker_core_macros.svh"

module sltr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [sltr_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic [sltr_pkg::S_TUSER_W-1:0]   s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sltr_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                             m_tlast,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [sltr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [sltr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic flag_hit;
	logic flag_miss;
	logic flag_evict;
	logic data_access;

	assign flag_hit    = m_tdata[sltr_pkg::MB_HIT];
	assign flag_miss   = m_tdata[sltr_pkg::MB_MISS];
	assign flag_evict  = m_tdata[sltr_pkg::MB_EVICT];
	assign data_access = s_tvalid && s_tready && (s_tuser != sltr_pkg::OP_INSTR);

	// Every result is either a hit or a miss.
	`SLTR_ASSERT_IMPL(a_hit_xor_miss, clk, arst_n, m_tvalid, flag_hit != flag_miss)

	// Only a miss can evict.
	`SLTR_ASSERT_IMPL(a_evict_on_miss, clk, arst_n, m_tvalid && flag_evict, flag_miss)

	// A data access keeps the input closed while it is looked up.
	`SLTR_ASSERT_NEXT(a_busy_after_access, clk, arst_n, data_access, !s_tready)

	// A waiting result holds until it is taken.
	`SLTR_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind set_assoc_lru_cache_tracker_core sltr_checker u_sltr_checker (.*);

// ===== tb/set_assoc_lru_cache_tracker_core_checker.sv =====
// Result checker for the set-associative LRU cache tracker testbench.
// Mirrors the tag, valid and age arrays from the observed transfers and
// compares every result transfer. Depends on sltr_pkg only.
`timescale 1ns / 100ps

module set_assoc_lru_cache_tracker_core_checker #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int AGE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [sltr_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [sltr_pkg::S_TUSER_W-1:0]   s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [sltr_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             m_tlast,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [sltr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sltr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               pending,
	output int                               results_checked
);

	import sltr_pkg::*;

	// Largest set index width whose set count still fits in MAX_SETS.
	localparam int SET_BITS_CAP = $clog2(MAX_SETS + 1) - 1;
	localparam int HIT_TOTAL_LO = MB_EVICT + 1;
	localparam int MISS_TOTAL_LO = HIT_TOTAL_LO + TOTAL_W;
	localparam int EVICT_TOTAL_LO = MISS_TOTAL_LO + TOTAL_W;

	typedef struct packed {
		logic               hit;
		logic               miss;
		logic               evict;
		logic               last;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
		logic [TOTAL_W-1:0] evict_total;
	} access_result_t;

	logic [SET_BITS_W-1:0]   geo_set_bits;
	logic [BLOCK_BITS_W-1:0] geo_block_bits;
	logic [WAYS_USED_W-1:0]  geo_ways_used;

	logic                 line_valid [MAX_SETS][MAX_WAYS];
	logic [TAG_W-1:0]     line_tag   [MAX_SETS][MAX_WAYS];
	logic [AGE_WIDTH-1:0] line_age   [MAX_SETS][MAX_WAYS];
	logic [TOTAL_W-1:0]   hits_seen;
	logic [TOTAL_W-1:0]   misses_seen;
	logic [TOTAL_W-1:0]   evictions_seen;

	access_result_t expected_results [$];
	access_result_t got;
	access_result_t want;
	logic [M_PAD_W-1:0] got_pad;
	int s_i;
	int w_i;

	// One tag lookup and LRU update of the mirrored cache.
	function automatic access_result_t cache_access(input logic [ADDR_W-1:0] addr,
		input logic is_last);
		int sb;
		int nways;
		int set_idx;
		int shift;
		int pick;
		int w;
		logic [TAG_W-1:0] tag;
		logic found;
		logic have_free;
		logic evict;
		logic [AGE_WIDTH-1:0] best;
		access_result_t r;

		sb = (geo_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(geo_set_bits);
		nways = (geo_ways_used < 1) ? 1 :
			(geo_ways_used > MAX_WAYS) ? MAX_WAYS : int'(geo_ways_used);
		set_idx = int'((addr >> geo_block_bits) & ((64'd1 << sb) - 64'd1)) % MAX_SETS;
		shift = int'(geo_block_bits) + sb;
		tag = (shift < 64) ? (addr >> shift) : '0;

		found = 1'b0;
		evict = 1'b0;
		pick = 0;
		for (w = 0; w < nways; w++) begin
			if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
				pick = w;
				found = 1'b1;
			end
		end

		if (found) begin
			if (hits_seen != '1)
				hits_seen++;
		end else begin
			if (misses_seen != '1)
				misses_seen++;
			// First free way wins; otherwise the oldest, lowest index on a tie.
			have_free = 1'b0;
			best = '0;
			for (w = 0; w < nways; w++) begin
				if (!have_free) begin
					if (!line_valid[set_idx][w]) begin
						pick = w;
						have_free = 1'b1;
					end else if (line_age[set_idx][w] > best) begin
						best = line_age[set_idx][w];
						pick = w;
					end
				end
			end
			if (!have_free) begin
				evict = 1'b1;
				if (evictions_seen != '1)
					evictions_seen++;
			end
			line_valid[set_idx][pick] = 1'b1;
			line_tag[set_idx][pick] = tag;
		end

		line_age[set_idx][pick] = '0;
		for (w = 0; w < nways; w++) begin
			if (w != pick && line_age[set_idx][w] != '1)
				line_age[set_idx][w]++;
		end

		r.hit = found;
		r.miss = !found;
		r.evict = evict;
		r.last = is_last;
		r.hit_total = hits_seen;
		r.miss_total = misses_seen;
		r.evict_total = evictions_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_set_bits = 4'd4;
			geo_block_bits = 6'd4;
			geo_ways_used = 4'd1;
			for (s_i = 0; s_i < MAX_SETS; s_i++) begin
				for (w_i = 0; w_i < MAX_WAYS; w_i++) begin
					line_valid[s_i][w_i] = 1'b0;
					line_tag[s_i][w_i] = '0;
					line_age[s_i][w_i] = '0;
				end
			end
			hits_seen = '0;
			misses_seen = '0;
			evictions_seen = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SET_BITS:   geo_set_bits = cfg_data[SET_BITS_W-1:0];
					REG_BLOCK_BITS: geo_block_bits = cfg_data[BLOCK_BITS_W-1:0];
					REG_WAYS_USED:  geo_ways_used = cfg_data[WAYS_USED_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_LOAD, OP_STORE:
						expected_results.push_back(cache_access(s_tdata, 1'b1));
					OP_MODIFY: begin
						expected_results.push_back(cache_access(s_tdata, 1'b0));
						expected_results.push_back(cache_access(s_tdata, 1'b1));
					end
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.hit = m_tdata[MB_HIT];
				got.miss = m_tdata[MB_MISS];
				got.evict = m_tdata[MB_EVICT];
				got.last = m_tlast;
				got.hit_total = m_tdata[HIT_TOTAL_LO +: TOTAL_W];
				got.miss_total = m_tdata[MISS_TOTAL_LO +: TOTAL_W];
				got.evict_total = m_tdata[EVICT_TOTAL_LO +: TOTAL_W];
				got_pad = m_tdata[M_TDATA_W-1 -: M_PAD_W];
				results_checked++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR %0t: result transfer with none expected", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (got != want || got_pad != '0) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("ERROR %0t: expected h%0b m%0b e%0b l%0b %0d/%0d/%0d",
								$realtime, want.hit, want.miss, want.evict, want.last,
								want.hit_total, want.miss_total, want.evict_total);
							$display("  got h%0b m%0b e%0b l%0b %0d/%0d/%0d pad %0h",
								got.hit, got.miss, got.evict, got.last, got.hit_total,
								got.miss_total, got.evict_total, got_pad);
						end
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/set_assoc_lru_cache_tracker_core_test.sv =====
// Top of the set-associative LRU cache tracker testbench: clock, reset,
// access and configuration stimulus, and the verdict. Depends on sltr_pkg,
// the tracker core and set_assoc_lru_cache_tracker_core_checker.
`timescale 1ns / 100ps

module set_assoc_lru_cache_tracker_core_test;

	import sltr_pkg::*;

	localparam int MAX_SETS = 256;
	localparam int MAX_WAYS = 8;
	localparam int AGE_WIDTH = 32;
	localparam int SET_BITS_CAP = $clog2(MAX_SETS + 1) - 1;
	// Longer than a modify holds the core with every way in use.
	localparam int SETTLE_CYCLES = 2 * MAX_WAYS + 12;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int POOL_SIZE = 16;
	localparam int NUM_PHASES = 10;
	// The core ignores this index; writing it checks that nothing changes.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [S_TUSER_W-1:0]   s_tuser = OP_LOAD;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SET_BITS;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int results_checked;

	// Idling is switched off for whole phases and for the closing phase.
	bit idling_on = 1'b1;
	int stall_left = 0;
	int accesses_sent = 0;

	// Geometry as last written, used to aim addresses at a few crowded sets.
	int geo_set_bits = 4;
	int geo_block_bits = 4;

	// Fixed geometries: many ways on few sets, the clamp of set_bits above
	// the set count, block offsets that push the tag off the top of the
	// address, a zero block offset, and way counts of zero and above the
	// number of ways built. The last two phases pick a random geometry.
	int phase_set_bits [8] = '{2, 0, 8, 15, 12, 8, 1, 4};
	int phase_block_bits [8] = '{4, 1, 6, 32, 63, 56, 0, 5};
	int phase_ways [8] = '{4, 8, 8, 15, 0, 2, 3, 6};

	always #5 clk = ~clk;

	set_assoc_lru_cache_tracker_core #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.AGE_WIDTH (AGE_WIDTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	set_assoc_lru_cache_tracker_core_checker #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.AGE_WIDTH (AGE_WIDTH)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// Result sink. The ready line drops for random bursts, so stalls land
	// on both results of a modify and on the write-back.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Register write. Called at a falling edge; returns at a falling edge
	// after the transfer, with the channel idle again.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// New geometry. The core must be idle first: all results in, and enough
	// further cycles for a trailing access or write-back to finish. The
	// access line is released so the last access is not taken twice.
	task automatic set_geometry(input int set_bits, input int block_bits, input int ways);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		write_reg(REG_SET_BITS, set_bits);
		write_reg(REG_BLOCK_BITS, block_bits);
		write_reg(REG_UNUSED, $urandom_range(0, 63));
		write_reg(REG_WAYS_USED, ways);
		geo_set_bits = set_bits;
		geo_block_bits = block_bits;
	endtask

	// One access transfer. Called at a falling edge. After the handshake the
	// valid line either stays high for the next access or drops for a burst.
	task automatic send_access(input logic [S_TUSER_W-1:0] op, input logic [S_TDATA_W-1:0] addr);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = addr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (op != OP_INSTR)
			accesses_sent++;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 18))
				@(negedge clk);
		end
	endtask

	// Random accesses under the current geometry. Most addresses come from a
	// small pool of lines spread over up to three sets with up to ten tags each,
	// more tags than ways, so hits, fills and LRU evictions all occur. The
	// rest are fully random addresses, pool lines with one random bit flipped,
	// and instruction accesses, which the core drops.
	task automatic random_phase(input int count);
		logic [S_TDATA_W-1:0] addr_pool [POOL_SIZE];
		logic [S_TDATA_W-1:0] tag;
		logic [S_TDATA_W-1:0] offset_mask;
		logic [S_TDATA_W-1:0] addr;
		logic [S_TUSER_W-1:0] op;
		int sb;
		int shift;
		int k;
		int done;
		int roll;

		sb = (geo_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : geo_set_bits;
		shift = geo_block_bits + sb;
		offset_mask = (64'd1 << geo_block_bits) - 64'd1;
		for (k = 0; k < POOL_SIZE; k++) begin
			tag = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 9)) : {$urandom, $urandom};
			addr_pool[k] = ((shift < 64) ? (tag << shift) : 64'd0)
				| ((64'($urandom_range(0, 2)) & ((64'd1 << sb) - 64'd1)) << geo_block_bits);
		end

		done = 0;
		while (done < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				op = OP_INSTR;
			else begin
				case ($urandom_range(0, 2))
					0: op = OP_LOAD;
					1: op = OP_STORE;
					default: op = OP_MODIFY;
				endcase
			end
			roll = $urandom_range(0, 99);
			addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (roll < 75)
				addr = addr | ({$urandom, $urandom} & offset_mask);
			else if (roll < 90)
				addr = {$urandom, $urandom};
			else
				addr = addr ^ (64'd1 << $urandom_range(0, 63));
			send_access(op, addr);
			if (op != OP_INSTR)
				done++;
		end
	endtask

	initial begin
		int p;

		// Reset once, released away from the rising edge.
		arst_n = 1'b0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed accesses under the reset geometry: 4 set bits, 4 offset
		// bits, one way, so every conflicting tag evicts. They cover both
		// address extremes, alternating bit patterns, a modify that misses
		// then hits, a modify that hits twice, and dropped instructions.
		send_access(OP_LOAD, 64'h0);
		send_access(OP_LOAD, 64'h8);
		send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(OP_MODIFY, 64'h10);
		send_access(OP_INSTR, 64'h10);
		send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0);
		send_access(OP_LOAD, 64'h100);
		send_access(OP_LOAD, 64'h0);
		send_access(OP_STORE, 64'h8000_0000_0000_0000);
		send_access(OP_LOAD, 64'h5555_5555_5555_5555);
		send_access(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_access(OP_INSTR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(OP_MODIFY, 64'h0123_4567_89AB_CDEF);
		send_access(OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
		send_access(OP_STORE, 64'h0000_0000_0000_0105);
		send_access(OP_MODIFY, 64'h8000_0000_0000_0000);

		// Geometry phases. The cache is never flushed in between, so each
		// phase also sees lines left by the previous geometry.
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p < 8)
				set_geometry(phase_set_bits[p], phase_block_bits[p], phase_ways[p]);
			else
				set_geometry($urandom_range(0, 15), $urandom_range(0, 63),
					$urandom_range(0, 15));
			idling_on = (p % 3 != 2) && (p != NUM_PHASES - 1);
			random_phase(ITEMS_PER_PHASE);
		end
		s_tvalid = 1'b0;

		// Drain, then give the core time to finish any last write-back.
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);

		$display("Covered %0d cache accesses over %0d geometries; %0d results checked.",
			accesses_sent, NUM_PHASES + 1, results_checked);
		if (fail_count == 0 && pending == 0)
			$display("set_assoc_lru_cache_tracker_core_test OK");
		else
			$display("set_assoc_lru_cache_tracker_core_test NOT OK");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run with every stall maxed.
	initial begin
		#5000000;
		$display("Timeout: core stopped making progress.");
		$display("set_assoc_lru_cache_tracker_core_test NOT OK");
		$finish;
	end

endmodule
